### rtl/fwrcs_pkg.sv
package fwrcs_pkg;

    localparam int NUM_CLASSES_DEF     = 4;
    localparam int QUEUE_DEPTH_DEF     = 64;
    localparam int FLOWS_PER_CLASS_DEF = 16;

    localparam int LIMIT_W = 7;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_QUEUED     = 3'd0,
        ST_QUEUE_FULL = 3'd1,
        ST_FLOW_FULL  = 3'd2,
        ST_SENT       = 3'd3,
        ST_IDLE       = 3'd4
    } status_t;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  service_class;
        logic [7:0]  sender_number;
        logic [7:0]  flow_number;
        logic [15:0] packet_tag;
        logic [15:0] random_fraction;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  sent_class;
        logic [7:0]  sent_sender;
        logic [7:0]  sent_flow;
        logic [15:0] sent_tag;
    } rsp_t;

endpackage

### rtl/flow_weighted_random_class_scheduler.sv
// Steps: a push runs from accept through S_FRD and S_FCHK for each flow slot scanned
// (up to FLOWS_PER_CLASS), one slot at a time through the flow memory read port, to
// S_DONE; a tick walks the classes in S_CSCAN, pops the head packet in S_PRD and S_PQ,
// then scans the slots the same way. A push to a full queue or a tick with no active
// flow goes straight to S_DONE. One item at a time: s_ready is high only in S_IDLE.
// Reset (aresetn low, synchronous): state idle, all flows invalid, counts and limit zero.
module flow_weighted_random_class_scheduler #(
    parameter int NUM_CLASSES     = fwrcs_pkg::NUM_CLASSES_DEF,
    parameter int QUEUE_DEPTH     = fwrcs_pkg::QUEUE_DEPTH_DEF,
    parameter int FLOWS_PER_CLASS = fwrcs_pkg::FLOWS_PER_CLASS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  fwrcs_pkg::req_t                    s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output fwrcs_pkg::rsp_t                    m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fwrcs_pkg::LIMIT_W-1:0]      cfg_data
);

    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SLOT_W  = (FLOWS_PER_CLASS > 1) ? $clog2(FLOWS_PER_CLASS) : 1;
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W   = OCC_W;
    localparam int CFC_W   = $clog2(FLOWS_PER_CLASS + 1);
    localparam int NFLOWS  = NUM_CLASSES * FLOWS_PER_CLASS;
    localparam int TOT_W   = $clog2(NFLOWS + 1);
    localparam int FIDX_W  = (NFLOWS > 1) ? $clog2(NFLOWS) : 1;
    localparam int NPKT    = NUM_CLASSES * QUEUE_DEPTH;
    localparam int PIDX_W  = $clog2(NPKT);
    localparam int LIM_W   = (OCC_W > fwrcs_pkg::LIMIT_W) ? OCC_W : fwrcs_pkg::LIMIT_W;
    localparam int FENT_W  = 16 + CNT_W;
    localparam int PROD_W  = 16 + TOT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CSCAN, S_PRD, S_PQ, S_FRD, S_FCHK, S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]       sender;
        logic [7:0]       flow;
        logic [CNT_W-1:0] count;
    } fent_t;

    // Storage: per-class packet rings and per-class flow tables
    logic [31:0]     pkt_mem [NPKT];
    logic [FENT_W-1:0] flow_mem [NFLOWS];
    logic [31:0]     pkt_q_reg;
    fent_t           flow_q_reg;

    logic                pkt_we;
    logic [PIDX_W-1:0]   pkt_wa;
    logic [31:0]         pkt_wd;
    logic [PIDX_W-1:0]   pkt_ra;
    logic                flow_we;
    logic [FIDX_W-1:0]   flow_wa;
    fent_t               flow_wd;
    logic [FIDX_W-1:0]   flow_ra;

    state_t              state_reg, state_next;
    logic [fwrcs_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [HEAD_W-1:0]   head_reg [NUM_CLASSES];
    logic [HEAD_W-1:0]   head_next [NUM_CLASSES];
    logic [OCC_W-1:0]    occ_reg [NUM_CLASSES];
    logic [OCC_W-1:0]    occ_next [NUM_CLASSES];
    logic [CFC_W-1:0]    cfc_reg [NUM_CLASSES];
    logic [CFC_W-1:0]    cfc_next [NUM_CLASSES];
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [NFLOWS-1:0]   fvalid_reg, fvalid_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TOT_W-1:0]    sel_reg, sel_next;
    logic                tick_reg, tick_next;
    logic [7:0]          key_s_reg, key_s_next;
    logic [7:0]          key_f_reg, key_f_next;
    logic [15:0]         tag_reg, tag_next;
    fwrcs_pkg::rsp_t     res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    fwrcs_pkg::rsp_t     m_data_reg, m_data_next;

    // Combinational helpers
    logic [CLS_W-1:0]    in_cls;
    logic [PROD_W-1:0]   prod;
    logic [LIM_W-1:0]    lim;
    logic [FIDX_W-1:0]   fbase;
    logic [FIDX_W-1:0]   faddr;
    logic [PIDX_W-1:0]   pbase;
    logic [HEAD_W:0]     tail_sum;
    logic [HEAD_W-1:0]   tail_pos;
    logic                match;
    logic                last_slot;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
    logic [FIDX_W-1:0]   free_addr;
    logic [CNT_W-1:0]    dec_cnt;
    fwrcs_pkg::rsp_t     rsp_zero;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        // Clamp an out-of-range class onto the last one
        if ({{(CLS_W + 2){1'b0}}, s_data.service_class} >= (CLS_W + 4)'(NUM_CLASSES)) begin
            in_cls = CLS_W'(NUM_CLASSES - 1);
        end else begin
            in_cls = CLS_W'(s_data.service_class);
        end
        prod = PROD_W'(s_data.random_fraction) * PROD_W'(total_reg);
        if (limit_reg != '0 && LIM_W'(limit_reg) < LIM_W'(QUEUE_DEPTH)) begin
            lim = LIM_W'(limit_reg);
        end else begin
            lim = LIM_W'(QUEUE_DEPTH);
        end
        fbase    = FIDX_W'(FIDX_W'(cls_reg) * FIDX_W'(FLOWS_PER_CLASS));
        faddr    = FIDX_W'(fbase + FIDX_W'(slot_reg));
        pbase    = PIDX_W'(PIDX_W'(cls_reg) * PIDX_W'(QUEUE_DEPTH));
        tail_sum = (HEAD_W + 1)'(head_reg[cls_reg]) + (HEAD_W + 1)'(occ_reg[cls_reg]);
        if (tail_sum >= (HEAD_W + 1)'(QUEUE_DEPTH)) begin
            tail_pos = HEAD_W'(tail_sum - (HEAD_W + 1)'(QUEUE_DEPTH));
        end else begin
            tail_pos = HEAD_W'(tail_sum);
        end
        match     = fvalid_reg[faddr] && flow_q_reg.sender == key_s_reg
                    && flow_q_reg.flow == key_f_reg;
        last_slot = (slot_reg == SLOT_W'(FLOWS_PER_CLASS - 1));
        // Lowest free slot of the class
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = FLOWS_PER_CLASS - 1; i >= 0; i--) begin
            if (!fvalid_reg[FIDX_W'(fbase + FIDX_W'(i))]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
        free_addr = FIDX_W'(fbase + FIDX_W'(free_slot));
        dec_cnt   = (flow_q_reg.count != '0) ? CNT_W'(flow_q_reg.count - 1'b1) : '0;
        rsp_zero  = '0;
    end

    always_comb begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        head_next    = head_reg;
        occ_next     = occ_reg;
        cfc_next     = cfc_reg;
        total_next   = total_reg;
        fvalid_next  = fvalid_reg;
        cls_next     = cls_reg;
        slot_next    = slot_reg;
        sel_next     = sel_reg;
        tick_next    = tick_reg;
        key_s_next   = key_s_reg;
        key_f_next   = key_f_reg;
        tag_next     = tag_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        pkt_we       = 1'b0;
        pkt_wa       = PIDX_W'(pbase + PIDX_W'(tail_pos));
        pkt_wd       = {key_s_reg, key_f_reg, tag_reg};
        pkt_ra       = PIDX_W'(pbase + PIDX_W'(head_reg[cls_reg]));
        flow_we      = 1'b0;
        flow_wa      = faddr;
        flow_wd      = flow_q_reg;
        flow_ra      = faddr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    tick_next  = (s_data.req_type == fwrcs_pkg::REQ_TICK);
                    key_s_next = s_data.sender_number;
                    key_f_next = s_data.flow_number;
                    tag_next   = s_data.packet_tag;
                    slot_next  = '0;
                    res_next   = rsp_zero;
                    if (s_data.req_type == fwrcs_pkg::REQ_TICK) begin
                        cls_next = '0;
                        sel_next = TOT_W'(prod >> 16);
                        if (total_reg == '0) begin
                            res_next.status = fwrcs_pkg::ST_IDLE;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_CSCAN;
                        end
                    end else begin
                        cls_next = in_cls;
                        if (LIM_W'(occ_reg[in_cls]) >= lim) begin
                            res_next.status = fwrcs_pkg::ST_QUEUE_FULL;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_FRD;
                        end
                    end
                end
            end
            S_CSCAN: begin
                // Walk the cumulative distinct-flow counts
                if (sel_reg < TOT_W'(cfc_reg[cls_reg])) begin
                    if (occ_reg[cls_reg] == '0) begin
                        res_next.status = fwrcs_pkg::ST_IDLE;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_PRD;
                    end
                end else if (cls_reg == CLS_W'(NUM_CLASSES - 1)) begin
                    res_next.status = fwrcs_pkg::ST_IDLE;
                    state_next      = S_DONE;
                end else begin
                    sel_next = TOT_W'(sel_reg - TOT_W'(cfc_reg[cls_reg]));
                    cls_next = CLS_W'(cls_reg + 1'b1);
                end
            end
            S_PRD: begin
                state_next = S_PQ;
            end
            S_PQ: begin
                // Pop the head packet and look up its flow
                key_s_next = pkt_q_reg[31:24];
                key_f_next = pkt_q_reg[23:16];
                tag_next   = pkt_q_reg[15:0];
                if (head_reg[cls_reg] == HEAD_W'(QUEUE_DEPTH - 1)) begin
                    head_next[cls_reg] = '0;
                end else begin
                    head_next[cls_reg] = HEAD_W'(head_reg[cls_reg] + 1'b1);
                end
                occ_next[cls_reg] = OCC_W'(occ_reg[cls_reg] - 1'b1);
                state_next        = S_FRD;
            end
            S_FRD: begin
                state_next = S_FCHK;
            end
            S_FCHK: begin
                if (!tick_reg) begin
                    if (match || (last_slot && free_found)) begin
                        flow_we = 1'b1;
                        if (match) begin
                            flow_wd.count = CNT_W'(flow_q_reg.count + 1'b1);
                        end else begin
                            flow_wa                = free_addr;
                            flow_wd.sender         = key_s_reg;
                            flow_wd.flow           = key_f_reg;
                            flow_wd.count          = CNT_W'(1);
                            fvalid_next[free_addr] = 1'b1;
                            cfc_next[cls_reg]      = CFC_W'(cfc_reg[cls_reg] + 1'b1);
                            total_next             = TOT_W'(total_reg + 1'b1);
                        end
                        pkt_we            = 1'b1;
                        occ_next[cls_reg] = OCC_W'(occ_reg[cls_reg] + 1'b1);
                        res_next.status   = fwrcs_pkg::ST_QUEUED;
                        state_next        = S_DONE;
                    end else if (last_slot) begin
                        res_next.status = fwrcs_pkg::ST_FLOW_FULL;
                        state_next      = S_DONE;
                    end else begin
                        slot_next  = SLOT_W'(slot_reg + 1'b1);
                        state_next = S_FRD;
                    end
                end else begin
                    if (match || last_slot) begin
                        if (match) begin
                            flow_we       = 1'b1;
                            flow_wd.count = dec_cnt;
                            if (dec_cnt == '0) begin
                                fvalid_next[faddr] = 1'b0;
                                if (cfc_reg[cls_reg] != '0) begin
                                    cfc_next[cls_reg] = CFC_W'(cfc_reg[cls_reg] - 1'b1);
                                end
                                if (total_reg != '0) begin
                                    total_next = TOT_W'(total_reg - 1'b1);
                                end
                            end
                        end
                        res_next.status      = fwrcs_pkg::ST_SENT;
                        res_next.sent_class  = 2'(cls_reg);
                        res_next.sent_sender = key_s_reg;
                        res_next.sent_flow   = key_f_reg;
                        res_next.sent_tag    = tag_reg;
                        state_next           = S_DONE;
                    end else begin
                        slot_next  = SLOT_W'(slot_reg + 1'b1);
                        state_next = S_FRD;
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pkt_we) begin
            pkt_mem[pkt_wa] <= pkt_wd;
        end
        pkt_q_reg <= pkt_mem[pkt_ra];
    end

    always_ff @(posedge aclk) begin
        if (flow_we) begin
            flow_mem[flow_wa] <= flow_wd;
        end
        flow_q_reg <= flow_mem[flow_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            limit_reg   <= '0;
            total_reg   <= '0;
            fvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
            cls_reg     <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= '0;
                occ_reg[i]  <= '0;
                cfc_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            total_reg   <= total_next;
            fvalid_reg  <= fvalid_next;
            m_valid_reg <= m_valid_next;
            cls_reg     <= cls_next;
            head_reg    <= head_next;
            occ_reg     <= occ_next;
            cfc_reg     <= cfc_next;
        end
        slot_reg   <= slot_next;
        sel_reg    <= sel_next;
        tick_reg   <= tick_next;
        key_s_reg  <= key_s_next;
        key_f_reg  <= key_f_next;
        tag_reg    <= tag_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOT_W'(NFLOWS))
        else $error("total flow count above table size");
    a_class_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        TOT_W'(cfc_reg[cls_reg]) <= total_reg)
        else $error("class flow count above total");
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg[cls_reg] <= OCC_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");
    a_beat_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside done state");
`endif

endmodule

### bench/flow_weighted_random_class_scheduler_tb.sv
module flow_weighted_random_class_scheduler_tb;

    localparam int NCLS     = fwrcs_pkg::NUM_CLASSES_DEF;
    localparam int QDEPTH   = fwrcs_pkg::QUEUE_DEPTH_DEF;
    localparam int NFLOWS   = fwrcs_pkg::FLOWS_PER_CLASS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_SHOWN   = 10;

    // Model of the scheduler state: per-class packet rings and flow tables.
    class sched_scoreboard;
        int unsigned limit_reg;
        logic [7:0]  ring_sender [NCLS][QDEPTH];
        logic [7:0]  ring_flow   [NCLS][QDEPTH];
        logic [15:0] ring_tag    [NCLS][QDEPTH];
        int unsigned head [NCLS];
        int unsigned occ  [NCLS];
        bit          fl_valid  [NCLS][NFLOWS];
        logic [7:0]  fl_sender [NCLS][NFLOWS];
        logic [7:0]  fl_flow   [NCLS][NFLOWS];
        int unsigned fl_count  [NCLS][NFLOWS];
        int unsigned cls_flows [NCLS];
        int unsigned all_flows;
        fwrcs_pkg::rsp_t pending [$];
        int          mismatches;

        function new();
            limit_reg = 0;
            all_flows = 0;
            mismatches = 0;
            for (int c = 0; c < NCLS; c++) begin
                head[c] = 0;
                occ[c] = 0;
                cls_flows[c] = 0;
                for (int i = 0; i < NFLOWS; i++) begin
                    fl_valid[c][i] = 0;
                    fl_count[c][i] = 0;
                end
            end
        endfunction

        function int find_slot(int c, logic [7:0] s, logic [7:0] f);
            for (int i = 0; i < NFLOWS; i++)
                if (fl_valid[c][i] && fl_sender[c][i] == s && fl_flow[c][i] == f)
                    return i;
            return NFLOWS;
        endfunction

        // Compute the response for one accepted request and update the state.
        function void note_request(fwrcs_pkg::req_t rq);
            fwrcs_pkg::rsp_t r;
            int c, slot, cap, pos;
            int unsigned sel;
            r = '0;
            r.status = fwrcs_pkg::ST_QUEUED;
            if (rq.req_type == fwrcs_pkg::REQ_PUSH) begin
                c = int'(rq.service_class);
                cap = (limit_reg != 0 && limit_reg < QDEPTH) ? limit_reg : QDEPTH;
                slot = find_slot(c, rq.sender_number, rq.flow_number);
                if (occ[c] >= cap) begin
                    r.status = fwrcs_pkg::ST_QUEUE_FULL;
                end else begin
                    if (slot == NFLOWS) begin
                        for (slot = 0; slot < NFLOWS; slot++)
                            if (!fl_valid[c][slot]) break;
                        if (slot < NFLOWS) begin
                            fl_valid[c][slot] = 1;
                            fl_sender[c][slot] = rq.sender_number;
                            fl_flow[c][slot] = rq.flow_number;
                            fl_count[c][slot] = 0;
                            cls_flows[c]++;
                            all_flows++;
                        end
                    end
                    if (slot == NFLOWS) begin
                        r.status = fwrcs_pkg::ST_FLOW_FULL;
                    end else begin
                        fl_count[c][slot]++;
                        pos = (head[c] + occ[c]) % QDEPTH;
                        ring_sender[c][pos] = rq.sender_number;
                        ring_flow[c][pos] = rq.flow_number;
                        ring_tag[c][pos] = rq.packet_tag;
                        occ[c]++;
                    end
                end
            end else if (all_flows == 0) begin
                r.status = fwrcs_pkg::ST_IDLE;
            end else begin
                sel = (32'(rq.random_fraction) * all_flows) >> 16;
                for (c = 0; c < NCLS; c++) begin
                    if (sel < cls_flows[c]) break;
                    sel -= cls_flows[c];
                end
                if (c == NCLS || occ[c] == 0) begin
                    r.status = fwrcs_pkg::ST_IDLE;
                end else begin
                    r.status = fwrcs_pkg::ST_SENT;
                    r.sent_class = 2'(c);
                    r.sent_sender = ring_sender[c][head[c]];
                    r.sent_flow = ring_flow[c][head[c]];
                    r.sent_tag = ring_tag[c][head[c]];
                    head[c] = (head[c] + 1) % QDEPTH;
                    occ[c]--;
                    slot = find_slot(c, r.sent_sender, r.sent_flow);
                    if (slot < NFLOWS) begin
                        if (fl_count[c][slot] > 0) fl_count[c][slot]--;
                        if (fl_count[c][slot] == 0) begin
                            fl_valid[c][slot] = 0;
                            cls_flows[c]--;
                            all_flows--;
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_response(fwrcs_pkg::rsp_t got);
            fwrcs_pkg::rsp_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected response beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.sent_class !== want.sent_class ||
                got.sent_sender !== want.sent_sender || got.sent_flow !== want.sent_flow ||
                got.sent_tag !== want.sent_tag) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display({"mismatch: expected st=%0d cls=%0d snd=%0d flw=%0d tag=%h,",
                              " got st=%0d cls=%0d snd=%0d flw=%0d tag=%h"},
                             want.status, want.sent_class, want.sent_sender, want.sent_flow,
                             want.sent_tag, got.status, got.sent_class, got.sent_sender,
                             got.sent_flow, got.sent_tag);
            end
        endfunction
    endclass

    logic   aclk = 0;
    logic   aresetn = 0;
    logic   s_valid = 0;
    logic   s_ready;
    fwrcs_pkg::req_t s_data = '0;
    logic   m_valid;
    logic   m_ready = 0;
    fwrcs_pkg::rsp_t m_data;
    logic   cfg_valid = 0;
    logic   cfg_ready;
    logic [fwrcs_pkg::LIMIT_W-1:0] cfg_data = '0;

    sched_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_recv = 0;
    int  idle_cycles = 0;

    always #4 aclk = ~aclk;

    flow_weighted_random_class_scheduler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Receiver: drop ready at random, or hold it low through a long back-pressure stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every response beat and watch for a stalled run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_response(m_data);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (sb.pending.size() != 0 || s_valid || cfg_valid)
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one request; note it in the scoreboard at the accepting edge, then drop
    // valid and wait out the next edge, during which the block is busy anyway.
    task automatic send_request(fwrcs_pkg::req_t rq);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1;
        s_data <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(rq);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic offer_push(int c, int s, int f, int tag);
        fwrcs_pkg::req_t rq;
        rq = '0;
        rq.req_type = fwrcs_pkg::REQ_PUSH;
        rq.service_class = 2'(c);
        rq.sender_number = 8'(s);
        rq.flow_number = 8'(f);
        rq.packet_tag = 16'(tag);
        rq.random_fraction = 16'($urandom);
        send_request(rq);
    endtask

    task automatic tick(int frac);
        fwrcs_pkg::req_t rq;
        rq = '0;
        rq.req_type = fwrcs_pkg::REQ_TICK;
        rq.service_class = 2'($urandom);
        rq.sender_number = 8'($urandom);
        rq.flow_number = 8'($urandom);
        rq.packet_tag = 16'($urandom);
        rq.random_fraction = 16'(frac);
        send_request(rq);
    endtask

    // Wait for all responses plus the longest per-item latency before a register write.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4 + NCLS + 2 * NFLOWS + 8) @(posedge aclk);
    endtask

    task automatic write_limit(int value);
        drain();
        cfg_valid <= 1;
        cfg_data <= fwrcs_pkg::LIMIT_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.limit_reg = value;
        cfg_valid <= 0;
    endtask

    // Random traffic: mostly pushes on a small flow pool, ticks in between.
    task automatic random_traffic(int count);
        repeat (count) begin
            if ($urandom_range(99) < 55)
                offer_push($urandom_range(NCLS - 1), $urandom_range(5), $urandom_range(7),
                           $urandom);
            else if ($urandom_range(9) == 0)
                offer_push($urandom_range(NCLS - 1), $urandom, $urandom, $urandom);
            else
                tick($urandom);
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: idle tick, extremes of each field, full flow table, queue limit.
        tick(16'hffff);
        offer_push(0, 0, 0, 16'h0000);
        offer_push(3, 255, 255, 16'hffff);
        tick(16'h0000);
        tick(16'hffff);
        tick(16'h8000);
        for (int i = 0; i <= NFLOWS; i++) offer_push(1, 8'haa, i, i);
        for (int i = 0; i < NFLOWS; i++) tick(16'hffff);

        write_limit(2);
        offer_push(2, 1, 1, 1);
        offer_push(2, 1, 1, 2);
        offer_push(2, 1, 2, 3);
        tick(0);
        tick(0);

        // Phase: sender slow, receiver slow, with a mid-range limit.
        send_idle_pct = 26;
        recv_idle_pct = 64;
        write_limit(5);
        random_traffic(250);

        // Phase: physical depth only; hold the receiver off so the block backs up.
        send_idle_pct = 64;
        recv_idle_pct = 26;
        write_limit(0);
        hold_recv = 1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_recv = 0;
            end
            random_traffic(30);
        join
        random_traffic(250);

        // Phase: no idling, largest limit, then the widest value the register holds.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(64);
        random_traffic(150);
        write_limit(127);
        random_traffic(150);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
